// ===== hdl/wsd_pkg.sv =====
// shared types, codes and constants for the websocket frame deframer
`timescale 1ns / 1ps
package wsd_pkg;

	localparam int LENGTH_BITS = 64;
	localparam int TIMER_BITS  = 16;
	localparam int TIMEOUT_W   = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_ON_PING = 1'd1;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_LEN     = 2'd1;
	localparam logic [1:0] PH_EXT     = 2'd2;
	localparam logic [1:0] PH_PAYLOAD = 2'd3;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [1:0] FRAME_TEXT   = 2'd0;
	localparam logic [1:0] FRAME_BINARY = 2'd1;
	localparam logic [1:0] FRAME_PING   = 2'd2;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_HEADER  = 2'd1;
	localparam logic [1:0] ERR_MASKED  = 2'd2;
	localparam logic [1:0] ERR_TIMEOUT = 2'd3;

	localparam logic [7:0] HDR_TEXT   = 8'h81;
	localparam logic [7:0] HDR_BINARY = 8'h82;
	localparam logic [7:0] HDR_PING   = 8'h89;

	localparam logic [6:0] LEN_CODE16 = 7'h7e;
	localparam logic [6:0] LEN_CODE64 = 7'h7f;

	localparam logic [3:0] EXT_BYTES16 = 4'd2;
	localparam logic [3:0] EXT_BYTES64 = 4'd8;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload;
		logic [1:0] frame_kind;
		logic       last;
		logic       notify;
		logic [1:0] error_code;
	} result_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic                 notify_on_ping;
	} cfg_t;

endpackage

// ===== hdl/wsd_if.sv =====
// valid/ready channel interfaces for input items and results
`timescale 1ns / 1ps
interface wsd_item_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface wsd_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] payload;
	logic [1:0] frame_kind;
	logic       last;
	logic       notify;
	logic [1:0] error_code;

	modport source (output valid, output kind, output payload, output frame_kind,
		output last, output notify, output error_code, input ready);
	modport sink (input valid, input kind, input payload, input frame_kind,
		input last, input notify, input error_code, output ready);
endinterface

// ===== hdl/wsd_in_stage.sv =====
// input register stage
`timescale 1ns / 1ps
module wsd_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  wsd_pkg::item_t in_item,
	output logic          valid_s1,
	input  logic          take,
	output wsd_pkg::item_t item_s1
);
	import wsd_pkg::*;

	logic vld_s1;

	assign in_ready = !vld_s1 || take;
	assign valid_s1 = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hdl/wsd_parser.sv =====
// frame parsing state and result register
`timescale 1ns / 1ps
module wsd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  wsd_pkg::cfg_t   cfg,
	input  logic            valid_s1,
	input  wsd_pkg::item_t  item_s1,
	output logic            take,
	output logic            res_valid,
	input  logic            res_ready,
	output wsd_pkg::result_t res
);
	import wsd_pkg::*;

	logic [1:0]             phase_q, phase_d;
	logic [1:0]             type_q, type_d;
	logic [3:0]             ext_q, ext_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic [TIMER_BITS-1:0]  idle_q, idle_d;

	logic                   res_valid_q;
	result_t                res_q;
	logic                   has_res;
	result_t                res_d;

	logic [TIMER_BITS-1:0]  idle_inc;
	logic [LENGTH_BITS-1:0] rem_sh;
	logic [LENGTH_BITS-1:0] rem_dec;
	logic [3:0]             ext_dec;
	logic [7:0]             b;
	logic                   end_ntf;

	assign take      = valid_s1 && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign b        = item_s1.rx_byte;
	assign end_ntf  = (type_q != FRAME_PING) || cfg.notify_on_ping;
	assign idle_inc = (idle_q != '1) ? idle_q + 1'b1 : idle_q;
	assign rem_sh   = {rem_q[LENGTH_BITS-9:0], b};
	assign rem_dec  = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
	assign ext_dec  = (ext_q != '0) ? ext_q - 1'b1 : ext_q;

	always_comb begin
		phase_d = phase_q;
		type_d  = type_q;
		ext_d   = ext_q;
		rem_d   = rem_q;
		idle_d  = idle_q;
		has_res = 1'b0;
		res_d   = '0;
		if (item_s1.opcode == OP_TICK) begin
			if (phase_q != PH_HEADER) begin
				idle_d = idle_inc;
				if (32'(idle_inc) >= 32'(cfg.timeout_ticks)) begin
					has_res          = 1'b1;
					res_d.kind       = KIND_ERROR;
					res_d.error_code = ERR_TIMEOUT;
					phase_d = PH_HEADER;
					ext_d   = '0;
					rem_d   = '0;
					idle_d  = '0;
				end
			end
		end else begin
			idle_d = '0;
			unique case (phase_q)
				PH_HEADER: begin
					priority if (b == HDR_TEXT) begin
						type_d  = FRAME_TEXT;
						phase_d = PH_LEN;
					end else if (b == HDR_BINARY) begin
						type_d  = FRAME_BINARY;
						phase_d = PH_LEN;
					end else if (b == HDR_PING) begin
						type_d  = FRAME_PING;
						phase_d = PH_LEN;
					end else begin
						has_res          = 1'b1;
						res_d.kind       = KIND_ERROR;
						res_d.error_code = ERR_HEADER;
						ext_d = '0;
						rem_d = '0;
					end
				end
				PH_LEN: begin
					rem_d = '0;
					priority if (b[7]) begin
						has_res          = 1'b1;
						res_d.kind       = KIND_ERROR;
						res_d.error_code = ERR_MASKED;
						phase_d = PH_HEADER;
						ext_d   = '0;
					end else if (b[6:0] == LEN_CODE16) begin
						ext_d   = EXT_BYTES16;
						phase_d = PH_EXT;
					end else if (b[6:0] == LEN_CODE64) begin
						ext_d   = EXT_BYTES64;
						phase_d = PH_EXT;
					end else if (b[6:0] == '0) begin
						has_res          = 1'b1;
						res_d.kind       = KIND_EMPTY;
						res_d.frame_kind = type_q;
						res_d.last       = 1'b1;
						res_d.notify     = end_ntf;
						phase_d = PH_HEADER;
						ext_d   = '0;
					end else begin
						rem_d   = LENGTH_BITS'(b[6:0]);
						phase_d = PH_PAYLOAD;
					end
				end
				PH_EXT: begin
					ext_d = ext_dec;
					rem_d = rem_sh;
					if (ext_dec == '0) begin
						if (rem_sh == '0) begin
							has_res          = 1'b1;
							res_d.kind       = KIND_EMPTY;
							res_d.frame_kind = type_q;
							res_d.last       = 1'b1;
							res_d.notify     = end_ntf;
							phase_d = PH_HEADER;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					has_res          = 1'b1;
					res_d.kind       = KIND_PAYLOAD;
					res_d.payload    = b;
					res_d.frame_kind = type_q;
					if (rem_dec == '0) begin
						res_d.last   = 1'b1;
						res_d.notify = end_ntf;
						phase_d = PH_HEADER;
						ext_d   = '0;
						rem_d   = '0;
					end else begin
						rem_d = rem_dec;
					end
				end
				default: begin
					phase_d = PH_HEADER;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			type_q      <= FRAME_TEXT;
			ext_q       <= '0;
			rem_q       <= '0;
			idle_q      <= '0;
			res_valid_q <= 1'b0;
		end else if (take) begin
			phase_q     <= phase_d;
			type_q      <= type_d;
			ext_q       <= ext_d;
			rem_q       <= rem_d;
			idle_q      <= idle_d;
			res_valid_q <= has_res;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_res) begin
			res_q <= res_d;
		end
	end

endmodule

// ===== hdl/websocket_frame_deframer.sv =====
// top level of the websocket frame deframer
`timescale 1ns / 1ps
// Receive-side websocket deframer. Each input transaction is either a stream
// byte or one timer tick; each byte or tick gives at most one result: a
// payload byte tagged with its frame type (last byte flagged), a completion
// for an empty frame, or an error (bad header, masked frame, timeout). A new
// transaction can be taken every cycle; a transaction passes through an input
// register and then the parser's result register. The input stalls only
// while the input register is full and the result register holds a result
// that is not being taken. timeout_ticks (index 0) and notify_on_ping
// (index 1) are written through the cfg port; the user must write them only
// while the block is idle, as the block itself does not enforce this.
module websocket_frame_deframer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wsd_pkg::CFG_DATA_W-1:0]   cfg_data,
	wsd_item_if.sink                         item_in,
	wsd_result_if.source                     result_out
);
	import wsd_pkg::*;

	cfg_t    cfg_q;
	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    take;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks  <= TIMEOUT_RESET;
			cfg_q.notify_on_ping <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT_TICKS:  cfg_q.timeout_ticks  <= cfg_data[TIMEOUT_W-1:0];
				REG_NOTIFY_ON_PING: cfg_q.notify_on_ping <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_item = {item_in.opcode, item_in.rx_byte};

	wsd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (item_in.ready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.take     (take),
		.item_s1  (item_s1)
	);

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.take      (take),
		.res_valid (result_out.valid),
		.res_ready (result_out.ready),
		.res       (res)
	);

	assign result_out.kind       = res.kind;
	assign result_out.payload    = res.payload;
	assign result_out.frame_kind = res.frame_kind;
	assign result_out.last       = res.last;
	assign result_out.notify     = res.notify;
	assign result_out.error_code = res.error_code;

endmodule
